>>> design/sprr_pkg.sv
// ----------------------------------------------------------------------------
// sprr_pkg: shared types and constants for the SHiP++ replacement block
// Line-state row layout, counter table sizes and action codes.
// ----------------------------------------------------------------------------
`default_nettype none
package sprr_pkg;
	localparam int SET_COUNT = 2048;
	localparam int WAY_COUNT = 16;
	localparam int SIGNATURE_BITS = 14;
	localparam int SET_W = $clog2(SET_COUNT);
	localparam int WAY_W = $clog2(WAY_COUNT);
	localparam int CTR_COUNT = 1 << SIGNATURE_BITS;

	// clearing pass covers the larger of the two memories
	localparam int CLR_W = (SIGNATURE_BITS > SET_W) ? SIGNATURE_BITS : SET_W;
	localparam int CLR_LAST = (CTR_COUNT > SET_COUNT) ? CTR_COUNT - 1 : SET_COUNT - 1;

	localparam logic [1:0] RRPV_MAX = 2'd3;
	localparam logic [2:0] CTR_MAX = 3'd7;
	localparam logic [2:0] CTR_RESET = 3'd1;
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_PREFETCH = 2'd2;
	localparam logic [1:0] KIND_WRITEBACK = 2'd3;
	localparam logic ACT_VICTIM = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	// configuration register indexes
	localparam logic [0:0] CFG_OVERRIDE = 1'b0;
	localparam logic [0:0] CFG_PF_TRAIN = 1'b1;

	// one line's state
	typedef struct packed {
		logic [SIGNATURE_BITS-1:0] sig;
		logic pf;
		logic reuse;
		logic [1:0] rrpv;
	} line_t;

	typedef struct packed {
		logic action;
		logic [10:0] set_index;
		logic [3:0] way;
		logic hit;
		logic [1:0] access_type;
		logic [12:0] pc_low;
		logic [6:0] random_draw;
	} req_t;

	typedef struct packed {
		logic [3:0] victim_way;
		logic [1:0] line_rrpv_after;
	} rsp_t;

	// reset image of one line
	function automatic line_t line_reset();
		line_t l;
		l.sig = '0;
		l.pf = 1'b0;
		l.reuse = 1'b0;
		l.rrpv = RRPV_MAX;
		return l;
	endfunction
endpackage
`default_nettype wire

>>> design/sprr_if.sv
// ----------------------------------------------------------------------------
// sprr_req_if / sprr_rsp_if: valid/ready channels
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface sprr_req_if;
	logic valid;
	logic ready;
	sprr_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sprr_rsp_if;
	logic valid;
	logic ready;
	sprr_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/sprr_ctr_ram.sv
// ----------------------------------------------------------------------------
// sprr_ctr_ram: signature counter table
// One-port synchronous RAM, one read or write a cycle, cleared epoch-free by
// its parent: a sweep after reset writes the reset value to every entry.
// ----------------------------------------------------------------------------
`default_nettype none
module sprr_ctr_ram (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [sprr_pkg::SIGNATURE_BITS-1:0] addr,
	input  wire logic [2:0] wdata,
	output logic [2:0] rdata
);
	logic [2:0] mem [sprr_pkg::CTR_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

>>> design/sprr_row_ram.sv
// ----------------------------------------------------------------------------
// sprr_row_ram: line-state memory, one row per set
// Each row holds every way of a set; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module sprr_row_ram (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [sprr_pkg::SET_W-1:0] addr,
	input  wire sprr_pkg::line_t [sprr_pkg::WAY_COUNT-1:0] wdata,
	output sprr_pkg::line_t [sprr_pkg::WAY_COUNT-1:0] rdata
);
	sprr_pkg::line_t [sprr_pkg::WAY_COUNT-1:0] mem [sprr_pkg::SET_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

>>> design/ship_plus_rrip_replacement.sv
// ----------------------------------------------------------------------------
// ship_plus_rrip_replacement: SHiP++ line replacement on an SRRIP base
// Keeps per-line RRPV, reuse, prefetch and signature state plus a table of
// saturating reuse counters indexed by signature.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: one word per cache access (find victim or update).
//  rsp channel: one word per request: victim way, or RRPV after update.
//  cfg port: index 0 override_percent, index 1 prefetch_train_percent.
//  Each word runs read row -> read/train old counter -> read new counter
//  -> write back; the response register loads at the write-back edge.
//  One word in flight at a time; the row memory and counter table are each
//  single ported and read-modify-write.
//  When the receiver holds ready low, the next word is still taken but waits
//  in its last step until the response register empties.
//  After reset a clearing pass sweeps max(SET_COUNT, 2^SIGNATURE_BITS) = 16384
//  addresses, writing every row and counter entry, with req.ready low.
//  Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none
module ship_plus_rrip_replacement (
	input  wire logic clk,
	input  wire logic arst_n,
	sprr_req_if.sink req,
	sprr_rsp_if.source rsp,
	input  wire logic cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [6:0] cfg_data
);
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_ROW   = 5'b00100,
		ST_CTR   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [sprr_pkg::CLR_W:0] clr_q;
	logic [6:0] ovr_q, pft_q;
	sprr_pkg::req_t req_q;
	sprr_pkg::line_t [sprr_pkg::WAY_COUNT-1:0] row_rd, row_wd, row_q;
	logic row_we, ctr_we;
	logic [sprr_pkg::SET_W-1:0] row_addr;
	logic [sprr_pkg::SIGNATURE_BITS-1:0] ctr_addr, new_sig, old_sig;
	logic [2:0] ctr_rd, ctr_wd;
	sprr_pkg::rsp_t rsp_q;
	logic rsp_valid_q;
	logic [1:0] phase_q;

	// request fields reduced to the array sizes
	logic [sprr_pkg::SET_W-1:0] set_s;
	logic [sprr_pkg::WAY_W-1:0] way_s;
	logic lead, is_pf, is_wb;
	sprr_pkg::line_t ln;
	assign set_s = req_q.set_index[sprr_pkg::SET_W-1:0];
	assign way_s = req_q.way[sprr_pkg::WAY_W-1:0];
	assign lead = ((~req_q.set_index[10:6]) == req_q.set_index[4:0]);
	assign is_pf = (req_q.access_type == sprr_pkg::KIND_PREFETCH);
	assign is_wb = (req_q.access_type == sprr_pkg::KIND_WRITEBACK);
	assign ln = row_q[way_s];
	assign old_sig = ln.sig;
	assign new_sig = sprr_pkg::SIGNATURE_BITS'({req_q.pc_low, is_pf});

	sprr_row_ram u_row (.clk, .we(row_we), .addr(row_addr), .wdata(row_wd), .rdata(row_rd));
	sprr_ctr_ram u_ctr (.clk, .we(ctr_we), .addr(ctr_addr), .wdata(ctr_wd), .rdata(ctr_rd));

	// row victim search: highest RRPV, first way
	logic [1:0] top;
	logic [sprr_pkg::WAY_W-1:0] first;
	always_comb begin
		top = '0;
		first = '0;
		for (int w = 0; w < sprr_pkg::WAY_COUNT; w++) begin
			if (row_q[w].rrpv > top) begin
				top = row_q[w].rrpv;
				first = sprr_pkg::WAY_W'(w);
			end
		end
	end

	// update rules for the addressed line; counter op chosen here
	sprr_pkg::line_t ln_n;
	logic ctr_inc_old, ctr_dec_old;
	always_comb begin
		ln_n = ln;
		ctr_inc_old = 1'b0;
		ctr_dec_old = 1'b0;
		if (req_q.hit) begin
			if (!is_wb) begin
				if (is_pf && ln.pf) begin
					if (lead && req_q.random_draw < pft_q) begin
						ctr_inc_old = 1'b1;
						ln_n.reuse = 1'b1;
					end
				end else begin
					ln_n.rrpv = ln.pf ? sprr_pkg::RRPV_MAX : 2'd0;
					ln_n.pf = 1'b0;
					if (lead && !ln.reuse) begin
						ctr_inc_old = 1'b1;
						ln_n.reuse = 1'b1;
					end
				end
			end
		end else begin
			if (lead) begin
				ctr_inc_old = ln.reuse;
				ctr_dec_old = !ln.reuse;
				ln_n.reuse = 1'b0;
				ln_n.sig = new_sig;
			end
			ln_n.pf = is_pf;
		end
	end

	// fill insertion from counter of the new signature (read after training)
	logic [1:0] ins_rrpv;
	always_comb begin
		if (is_wb) ins_rrpv = sprr_pkg::RRPV_MAX;
		else if (ctr_rd == 3'd0)
			ins_rrpv = (req_q.random_draw >= ovr_q) ? sprr_pkg::RRPV_MAX : 2'd2;
		else if (ctr_rd == sprr_pkg::CTR_MAX) ins_rrpv = {1'b0, is_pf};
		else ins_rrpv = 2'd2;
	end

	// the old signature's counter is trained only when a rule asks for it
	logic need_old;
	assign need_old = ctr_inc_old || ctr_dec_old;

	// new row image
	sprr_pkg::line_t [sprr_pkg::WAY_COUNT-1:0] row_new;
	always_comb begin
		row_new = row_q;
		if (req_q.action == sprr_pkg::ACT_VICTIM) begin
			for (int w = 0; w < sprr_pkg::WAY_COUNT; w++)
				row_new[w].rrpv = row_q[w].rrpv + (sprr_pkg::RRPV_MAX - top);
		end else begin
			row_new[way_s] = ln_n;
			if (!req_q.hit) row_new[way_s].rrpv = ins_rrpv;
		end
	end

	// write-back and response load share one edge
	logic row_wb;
	assign row_wb = (state_q == ST_OUT) && (phase_q == 2'd1) && (!rsp_valid_q || rsp.ready);

	// memory port control
	always_comb begin
		row_we = 1'b0;
		ctr_we = 1'b0;
		row_addr = set_s;
		ctr_addr = old_sig;
		ctr_wd = ctr_rd;
		row_wd = row_q;
		unique case (state_q)
			ST_CLEAR: begin
				row_we = 1'b1;
				ctr_we = 1'b1;
				row_addr = clr_q[sprr_pkg::SET_W-1:0];
				ctr_addr = clr_q[sprr_pkg::SIGNATURE_BITS-1:0];
				ctr_wd = sprr_pkg::CTR_RESET;
				for (int w = 0; w < sprr_pkg::WAY_COUNT; w++) row_wd[w] = sprr_pkg::line_reset();
			end
			ST_IDLE: begin
				row_addr = req.data.set_index[sprr_pkg::SET_W-1:0];
			end
			ST_ROW: begin
				// row_q just loaded next edge; address counter with old signature
				ctr_addr = row_rd[req_q.way[sprr_pkg::WAY_W-1:0]].sig;
			end
			ST_CTR: begin
				// ctr_rd is old signature's counter: train it
				ctr_addr = old_sig;
				ctr_we = (req_q.action == sprr_pkg::ACT_UPDATE) && need_old;
				ctr_wd = ctr_rd;
				if (ctr_inc_old && ctr_rd != sprr_pkg::CTR_MAX) ctr_wd = ctr_rd + 3'd1;
				if (ctr_dec_old && ctr_rd != 3'd0) ctr_wd = ctr_rd - 3'd1;
			end
			ST_OUT: begin
				ctr_addr = new_sig;
				row_we = row_wb;
				row_wd = row_new;
			end
			default: ;
		endcase
	end

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			ovr_q <= 7'd0;
			pft_q <= 7'd5;
			rsp_valid_q <= 1'b0;
			phase_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == sprr_pkg::CFG_OVERRIDE) ovr_q <= cfg_data;
				else pft_q <= cfg_data;
			end
			if (row_wb) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (sprr_pkg::CLR_W+1)'(sprr_pkg::CLR_LAST))
						state_q <= ST_IDLE;
				end
				ST_IDLE: if (req.valid && req.ready) state_q <= ST_ROW;
				ST_ROW: state_q <= ST_CTR;
				ST_CTR: begin
					phase_q <= '0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// phase 0 waits for the new-signature counter read
					if (phase_q == 2'd0) phase_q <= 2'd1;
					else if (!rsp_valid_q || rsp.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) req_q <= req.data;
		if (state_q == ST_ROW) row_q <= row_rd;
		if (row_wb) begin
			if (req_q.action == sprr_pkg::ACT_VICTIM) begin
				rsp_q.victim_way <= 4'(first);
				rsp_q.line_rrpv_after <= 2'd0;
			end else begin
				rsp_q.victim_way <= 4'd0;
				rsp_q.line_rrpv_after <= row_new[way_s].rrpv;
			end
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

`ifndef NO_ASSERTIONS
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.ready) else $error("accept during clear");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> $stable(rsp.data)) else $error("rsp changed");
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_ROW)) else $error("seq");
`endif
endmodule
`default_nettype wire
